// ===== sv/tws_pkg.sv =====
// Shared types, codes and defaults for the triggered write sequencer.
`default_nettype none

package tws_pkg;

    // Default geometry of the step tables.
    localparam int TRIGGERS_DEF = 4;
    localparam int STEPS_DEF    = 16;

    // Reset value of the end-of-sequence marker.
    localparam logic [15:0] END_MARKER_RST = 16'hFFFF;

    // Command codes of a request.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_FIRE = 2'd1;
    localparam logic [1:0] CMD_LOAD = 2'd2;

    // One request as presented on the command channel.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  trigger;
        logic [3:0]  entry;
        logic [15:0] entry_target;
        logic [15:0] entry_slot;
        logic [15:0] entry_data;
        logic [15:0] entry_hold;
    } req_t;

    // One write issued by the sequencer.
    typedef struct packed {
        logic [15:0] target_var;
        logic [15:0] target_slot;
        logic [15:0] write_data;
        logic [1:0]  from_trigger;
        logic        last;
    } res_t;

    // One stored step of a trigger's table.
    typedef struct packed {
        logic [15:0] target;
        logic [15:0] slot;
        logic [15:0] data;
        logic [15:0] hold;
    } step_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tws_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/triggered_write_sequencer_unit.sv =====
// Triggered write sequencer: step tables in RAM, a per-tick walk over all triggers.
//
// Usage. A request is taken at a clock edge where start is high and busy is low.
// A load request writes one step (target, slot, data, hold) of one trigger's table
// and a fire request arms an idle trigger at step 0; both leave busy low and
// produce no writes. A tick request walks triggers in ascending order; each armed
// trigger reads its current step from the step RAM and issues one write for every
// step it enters, until a step holds, the end marker is met or the table runs out.
// Writes leave on result in step-entry order, each for exactly one cycle, marked by
// result_strobe; the last write of a tick carries last set. The receiver cannot
// stall, so no output back-pressure exists.
// Timing. One write is held back one step so that the end of the tick can be
// flagged; the tick scans each trigger in turn, evaluates each step examined and
// ends with a flush. The single read port of the step RAM yields one step per cycle.
// busy is high for the whole tick.
// Reset. rst_n clears all triggers to disarmed and sets the end marker to 0xFFFF;
// the step RAM is not cleared and its entries must be loaded before use.
// Configuration. cfg_we with cfg_wdata writes the end marker; the user must do so
// only while idle, since the block itself does not enforce it.
`default_nettype none

module triggered_write_sequencer_unit
    import tws_pkg::*;
#(
    parameter int TRIGGERS = TRIGGERS_DEF,
    parameter int STEPS    = STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire req_t        request,
    output logic             busy,
    output res_t             result,
    output logic             result_strobe,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int DEPTH = TRIGGERS * STEPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (TRIGGERS > 1) ? $clog2(TRIGGERS) : 1;
    localparam int PW    = $clog2(STEPS);
    localparam logic [TW-1:0] LAST_TRIG = TW'(TRIGGERS - 1);
    localparam logic [PW-1:0] LAST_STEP = PW'(STEPS - 1);

    state_t state_reg, state_next;

    logic [TW-1:0] trig_reg, trig_next;
    logic          armed_reg   [TRIGGERS];
    logic          armed_next  [TRIGGERS];
    logic [PW-1:0] pos_reg     [TRIGGERS];
    logic [PW-1:0] pos_next    [TRIGGERS];
    logic [15:0]   hold_reg    [TRIGGERS];
    logic [15:0]   hold_next   [TRIGGERS];
    logic          entered_reg [TRIGGERS];
    logic          entered_next[TRIGGERS];

    logic [15:0] end_marker_reg;

    res_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    res_t result_reg, result_next;
    logic strobe_reg, strobe_next;

    logic          accept;
    logic          trig_ok;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;
    step_t         cur;
    logic [15:0]   hc;
    logic [PW-1:0] pos_cur;

    assign accept  = start && (state_reg == ST_IDLE);
    assign trig_ok = {1'b0, request.trigger} < 3'(TRIGGERS);
    assign cur     = step_t'(ram_rdata);
    assign pos_cur = pos_reg[trig_reg];
    assign hc      = hold_reg[trig_reg] + 16'd1;

    // Table loads go straight into the step RAM.
    assign ram_we    = accept && (request.cmd == CMD_LOAD) && trig_ok
                       && ({1'b0, request.entry} < 5'(STEPS));
    assign ram_waddr = AW'(request.trigger * STEPS) + AW'(request.entry);

    tws_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_step_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(64'({request.entry_target, request.entry_slot,
                    request.entry_data, request.entry_hold})),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // End marker register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            end_marker_reg <= cfg_wdata;
        end
    end

    // Sequencer and per-trigger state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            trig_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < TRIGGERS; i++)
            begin
                armed_reg[i]   <= 1'b0;
                pos_reg[i]     <= '0;
                hold_reg[i]    <= '0;
                entered_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            trig_reg       <= trig_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            for (int i = 0; i < TRIGGERS; i++)
            begin
                armed_reg[i]   <= armed_next[i];
                pos_reg[i]     <= pos_next[i];
                hold_reg[i]    <= hold_next[i];
                entered_reg[i] <= entered_next[i];
            end
        end
    end

    // Payload registers for the held-back write and the output.
    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    // Next state, step evaluation and write issue.
    always_comb
    begin
        logic trig_done;

        state_next      = state_reg;
        trig_next       = trig_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        armed_next      = armed_reg;
        pos_next        = pos_reg;
        hold_next       = hold_reg;
        entered_next    = entered_reg;
        ram_raddr       = AW'(trig_reg * STEPS) + AW'(pos_cur);
        trig_done       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.cmd == CMD_TICK)
                    begin
                        trig_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (request.cmd == CMD_FIRE && trig_ok)
                    begin
                        // A fire while running is ignored.
                        if (!armed_reg[request.trigger[TW-1:0]])
                        begin
                            armed_next[request.trigger[TW-1:0]]   = 1'b1;
                            pos_next[request.trigger[TW-1:0]]     = '0;
                            hold_next[request.trigger[TW-1:0]]    = '0;
                            entered_next[request.trigger[TW-1:0]] = 1'b0;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Start the read of the current step of an armed trigger.
                if (armed_reg[trig_reg])
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    trig_done = 1'b1;
                end
            end

            ST_EVAL:
            begin
                if (cur.target == end_marker_reg)
                begin
                    armed_next[trig_reg]   = 1'b0;
                    pos_next[trig_reg]     = '0;
                    hold_next[trig_reg]    = '0;
                    entered_next[trig_reg] = 1'b0;
                    trig_done              = 1'b1;
                end
                else
                begin
                    // Entering a step issues a write; the previous one goes out now.
                    if (!entered_reg[trig_reg])
                    begin
                        if (pend_valid_reg)
                        begin
                            result_next      = pend_reg;
                            result_next.last = 1'b0;
                            strobe_next      = 1'b1;
                        end
                        pend_next.target_var   = cur.target;
                        pend_next.target_slot  = cur.slot;
                        pend_next.write_data   = cur.data;
                        pend_next.from_trigger = 2'(trig_reg);
                        pend_next.last         = 1'b0;
                        pend_valid_next        = 1'b1;
                    end

                    if (cur.hold != 16'd0 && hc < cur.hold)
                    begin
                        hold_next[trig_reg]    = hc;
                        entered_next[trig_reg] = 1'b1;
                        trig_done              = 1'b1;
                    end
                    else if (pos_cur == LAST_STEP)
                    begin
                        armed_next[trig_reg]   = 1'b0;
                        pos_next[trig_reg]     = '0;
                        hold_next[trig_reg]    = '0;
                        entered_next[trig_reg] = 1'b0;
                        trig_done              = 1'b1;
                    end
                    else
                    begin
                        // Advance and read the next step straight away.
                        hold_next[trig_reg]    = '0;
                        entered_next[trig_reg] = 1'b0;
                        pos_next[trig_reg]     = pos_cur + PW'(1);
                        ram_raddr = AW'(trig_reg * STEPS) + AW'(pos_cur + PW'(1));
                    end
                end
            end

            ST_FLUSH:
            begin
                // The held-back write is the last one of the tick.
                if (pend_valid_reg)
                begin
                    result_next      = pend_reg;
                    result_next.last = 1'b1;
                    strobe_next      = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Move on to the next trigger or finish the tick.
        if (trig_done)
        begin
            if (trig_reg == LAST_TRIG)
            begin
                state_next = ST_FLUSH;
            end
            else
            begin
                trig_next  = trig_reg + TW'(1);
                state_next = ST_SCAN;
            end
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

`default_nettype wire

// ===== test/triggered_write_sequencer_unit_tb.sv =====
// Self-checking testbench for the triggered write sequencer unit.
`timescale 1ns / 1ps

module triggered_write_sequencer_unit_tb
    import tws_pkg::*;
();

    localparam int NTRIG         = TRIGGERS_DEF;
    localparam int NSTEP         = STEPS_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_GAP       = 18;
    // The one command code that the block has no use for.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    req_t        request;
    logic        busy;
    res_t        result;
    logic        result_strobe;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    triggered_write_sequencer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .request       (request),
        .busy          (busy),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Shadow copy of the sequencer state, kept in step with accepted requests.
    step_t       seq_table    [NTRIG*NSTEP];
    bit          entry_loaded [NTRIG*NSTEP];
    bit          seq_armed    [NTRIG];
    logic [4:0]  seq_pos      [NTRIG];
    logic [15:0] seq_hold_cnt [NTRIG];
    bit          seq_entered  [NTRIG];
    logic [15:0] seq_marker;

    // Writes still owed by the block, oldest first.
    res_t pending_writes[$];

    int mismatches;
    int accepted_count;
    bit no_gaps;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void disarm_trigger(int k);
        seq_armed[k]    = 1'b0;
        seq_pos[k]      = '0;
        seq_hold_cnt[k] = '0;
        seq_entered[k]  = 1'b0;
    endfunction

    // Update the shadow state for one accepted request and queue the writes it causes.
    function automatic void predict_writes(req_t r);
        res_t  tick_writes[$];
        res_t  w;
        step_t e;
        bit    done;
        int    idx;
        case (r.cmd)
            CMD_TICK:
            begin
                for (int k = 0; k < NTRIG; k++)
                begin
                    if (seq_armed[k])
                    begin
                        done = 1'b0;
                        while (!done)
                        begin
                            if (seq_pos[k] >= NSTEP)
                                seq_pos[k] = '0;
                            seq_hold_cnt[k] = seq_hold_cnt[k] + 16'd1;
                            e = seq_table[k*NSTEP + int'(seq_pos[k])];
                            if (e.target == seq_marker)
                            begin
                                disarm_trigger(k);
                                done = 1'b1;
                            end
                            else
                            begin
                                // Entering a step issues its write once.
                                if (!seq_entered[k])
                                begin
                                    seq_entered[k] = 1'b1;
                                    w.target_var   = e.target;
                                    w.target_slot  = e.slot;
                                    w.write_data   = e.data;
                                    w.from_trigger = k[1:0];
                                    w.last         = 1'b0;
                                    tick_writes.push_back(w);
                                end
                                if (e.hold != 16'd0 && seq_hold_cnt[k] < e.hold)
                                    done = 1'b1;
                                else
                                begin
                                    seq_hold_cnt[k] = '0;
                                    seq_entered[k]  = 1'b0;
                                    seq_pos[k]      = seq_pos[k] + 5'd1;
                                    if (seq_pos[k] >= NSTEP)
                                    begin
                                        disarm_trigger(k);
                                        done = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                // The final write of the tick carries last.
                if (tick_writes.size() > 0)
                begin
                    w = tick_writes.pop_back();
                    w.last = 1'b1;
                    tick_writes.push_back(w);
                end
                foreach (tick_writes[i])
                    pending_writes.push_back(tick_writes[i]);
            end
            CMD_FIRE:
            begin
                if (!seq_armed[r.trigger])
                begin
                    seq_armed[r.trigger] = 1'b1;
                    seq_pos[r.trigger]      = '0;
                    seq_hold_cnt[r.trigger] = '0;
                    seq_entered[r.trigger]  = 1'b0;
                end
            end
            CMD_LOAD:
            begin
                idx = int'(r.trigger)*NSTEP + int'(r.entry);
                seq_table[idx].target = r.entry_target;
                seq_table[idx].slot   = r.entry_slot;
                seq_table[idx].data   = r.entry_data;
                seq_table[idx].hold   = r.entry_hold;
                entry_loaded[idx]     = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Compare every strobed write with the oldest one owed.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_strobe === 1'b1)
        begin
            if (pending_writes.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected write: var=%h slot=%h data=%h trig=%0d last=%b",
                             result.target_var, result.target_slot, result.write_data,
                             result.from_trigger, result.last);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (result.target_var !== want.target_var ||
                    result.target_slot !== want.target_slot ||
                    result.write_data !== want.write_data ||
                    result.from_trigger !== want.from_trigger ||
                    result.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("write mismatch: expected var=%h slot=%h data=%h trig=%0d last=%b",
                                 want.target_var, want.target_slot, want.write_data,
                                 want.from_trigger, want.last);
                        $display("                got      var=%h slot=%h data=%h trig=%0d last=%b",
                                 result.target_var, result.target_slot, result.write_data,
                                 result.from_trigger, result.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    function automatic step_t random_step(bit may_end);
        step_t s;
        int    pick;
        pick = $urandom_range(0, 15);
        if (may_end && pick < 2)
            s.target = seq_marker;
        else if (pick == 2)
            s.target = 16'($urandom);
        else
        begin
            s.target = 16'($urandom);
            while (s.target == seq_marker)
                s.target = 16'($urandom);
        end
        s.slot = 16'($urandom);
        s.data = 16'($urandom);
        // Mostly short holds; now and then a long one that parks the trigger.
        pick = $urandom_range(0, 9);
        if (pick < 6)
            s.hold = 16'd0;
        else if (pick < 9)
            s.hold = 16'($urandom_range(1, 4));
        else
            s.hold = 16'($urandom);
        return s;
    endfunction

    function automatic req_t load_request(int t, int e, step_t s);
        req_t r;
        r              = '0;
        r.cmd          = CMD_LOAD;
        r.trigger      = t[1:0];
        r.entry        = e[3:0];
        r.entry_target = s.target;
        r.entry_slot   = s.slot;
        r.entry_data   = s.data;
        r.entry_hold   = s.hold;
        return r;
    endfunction

    function automatic req_t fire_request(int t);
        req_t r;
        r         = '0;
        r.cmd     = CMD_FIRE;
        r.trigger = t[1:0];
        return r;
    endfunction

    // Present one request after a random gap and wait until it is taken.
    // start is left high so that a back-to-back request needs no toggle.
    task automatic send_request(input req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = r;
        start   = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_writes(r);
        accepted_count++;
    endtask

    // Load any step that an armed trigger could still reach before it is walked.
    task automatic load_missing_steps();
        int p;
        int idx;
        for (int k = 0; k < NTRIG; k++)
        begin
            if (seq_armed[k])
            begin
                p = int'(seq_pos[k]);
                while (p < NSTEP)
                begin
                    idx = k*NSTEP + p;
                    if (!entry_loaded[idx])
                        send_request(load_request(k, p, random_step(1'b1)));
                    if (seq_table[idx].target == seq_marker)
                        break;
                    p++;
                end
            end
        end
    endtask

    task automatic send_tick();
        req_t r;
        r     = '0;
        r.cmd = CMD_TICK;
        load_missing_steps();
        send_request(r);
    endtask

    // Hold the sender off until every owed write has arrived and the block has settled.
    task automatic wait_until_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_marker(input logic [15:0] value);
        wait_until_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        seq_marker = value;
    endtask

    // A tick with nothing armed, then the spare command with every field set.
    task automatic test_idle_and_unknown();
        req_t r;
        send_tick();
        r     = '1;
        r.cmd = CMD_SPARE;
        send_request(r);
    endtask

    // Short sequence with a held step, fired twice, walked over several ticks.
    task automatic test_hold_and_refire();
        step_t s;
        s = '{target: 16'h0000, slot: 16'hFFFF, data: 16'h0000, hold: 16'd0};
        send_request(load_request(0, 0, s));
        s = '{target: 16'hFFFE, slot: 16'h0000, data: 16'hFFFF, hold: 16'd2};
        send_request(load_request(0, 1, s));
        s = '{target: 16'h0001, slot: 16'h5A5A, data: 16'hA5A5, hold: 16'd0};
        send_request(load_request(0, 2, s));
        s = '{target: seq_marker, slot: 16'h1234, data: 16'h4321, hold: 16'd0};
        send_request(load_request(0, 3, s));
        send_request(fire_request(0));
        send_request(fire_request(0));
        repeat (4) send_tick();
    endtask

    // A sequence that ends on its first step gives a quiet tick.
    task automatic test_marker_first();
        step_t s;
        s = '{target: seq_marker, slot: 16'h0F0F, data: 16'hF0F0, hold: 16'd7};
        send_request(load_request(1, 0, s));
        s = '{target: 16'hFFFF, slot: 16'hFFFF, data: 16'hFFFF, hold: 16'hFFFF};
        send_request(load_request(3, 15, s));
        send_request(fire_request(1));
        send_tick();
    endtask

    // With the marker at zero, a zero target ends the sequence.
    task automatic test_marker_zero();
        step_t s;
        set_marker(16'h0000);
        s = '{target: 16'h8000, slot: 16'h0001, data: 16'h8001, hold: 16'd0};
        send_request(load_request(2, 0, s));
        s = '{target: 16'h0000, slot: 16'h0000, data: 16'h0000, hold: 16'd0};
        send_request(load_request(2, 1, s));
        send_request(fire_request(2));
        send_tick();
    endtask

    // Load a well-formed table for one trigger, fire it and tick it along.
    task automatic run_sequence(int t);
        step_t s;
        int    len;
        if ($urandom_range(0, 3) == 0)
            len = NSTEP;
        else
            len = $urandom_range(1, 6);
        // Release a trigger that may be parked on a long hold.
        if (seq_armed[t])
        begin
            s      = random_step(1'b0);
            s.hold = 16'($urandom_range(0, 2));
            send_request(load_request(t, int'(seq_pos[t]), s));
        end
        for (int i = 0; i < len; i++)
            send_request(load_request(t, i, random_step(1'b0)));
        if (len < NSTEP)
        begin
            s        = random_step(1'b0);
            s.target = seq_marker;
            send_request(load_request(t, len, s));
        end
        send_request(fire_request(t));
        if ($urandom_range(0, 3) == 0)
            send_request(fire_request(t));
        repeat ($urandom_range(1, 5)) send_tick();
    endtask

    // Mostly well-formed sequences, with noise requests and pauses mixed in.
    task automatic test_random_traffic(int n_items);
        req_t r;
        int   goal;
        int   pick;
        goal = accepted_count + n_items;
        while (accepted_count < goal)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 19);
            if (pick < 14)
                run_sequence($urandom_range(0, NTRIG - 1));
            else if (pick < 19)
            begin
                r.cmd          = 2'($urandom);
                r.trigger      = 2'($urandom);
                r.entry        = 4'($urandom);
                r.entry_target = 16'($urandom);
                r.entry_slot   = 16'($urandom);
                r.entry_data   = 16'($urandom);
                r.entry_hold   = 16'($urandom);
                if (r.cmd == CMD_TICK)
                begin
                    load_missing_steps();
                    send_request(r);
                end
                else
                    send_request(r);
            end
            else
                wait_until_drained();
        end
        no_gaps = 1'b0;
    endtask

    // Every trigger runs to the end of its table in one tick.
    task automatic test_full_burst();
        step_t s;
        for (int t = 0; t < NTRIG; t++)
        begin
            for (int i = 0; i < NSTEP; i++)
            begin
                s      = random_step(1'b0);
                s.hold = 16'd0;
                send_request(load_request(t, i, s));
            end
        end
        for (int t = 0; t < NTRIG; t++)
            send_request(fire_request(t));
        send_tick();
    endtask

    // Test sequence.
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        no_gaps   = 1'b0;
        mismatches     = 0;
        accepted_count = 0;
        seq_marker     = END_MARKER_RST;
        for (int i = 0; i < NTRIG*NSTEP; i++)
        begin
            seq_table[i]    = '0;
            entry_loaded[i] = 1'b0;
        end
        for (int k = 0; k < NTRIG; k++)
            disarm_trigger(k);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_unknown();
        test_hold_and_refire();
        test_marker_first();
        test_marker_zero();
        test_random_traffic(50);
        set_marker(16'($urandom));
        test_random_traffic(50);
        test_full_burst();
        set_marker(16'hFFFF);
        test_random_traffic(50);
        wait_until_drained();

        if (mismatches == 0 && pending_writes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
